@@ src/htwd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// htwd_pkg
// Shared types, constants and helpers of the Huffman tree walk decoder.
// ----------------------------------------------------------------------------
package htwd_pkg;

    localparam int NODE_COUNT    = 512;
    localparam int SYMBOL_BITS   = 8;
    localparam int NODE_BITS     = $clog2(NODE_COUNT);
    localparam int IDX_BITS      = 9;
    localparam int IN_SYM_W      = 8;
    localparam int OUT_SYM_W     = 8;
    localparam int BYTE_W        = 8;
    localparam int BYTE_TOP_BIT  = 7;
    localparam int BITS_PER_BYTE = 8;
    localparam int BIT_CNT_W     = $clog2(BITS_PER_BYTE + 1);
    localparam int COUNT_W       = 32;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 32;
    localparam int KIND_W        = 2;
    localparam int IN_DATA_W     = 48;
    localparam int NODE_W        = 2 * NODE_BITS + 1 + SYMBOL_BITS;

    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_NODE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_TOTAL = 1'd1;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE = 2'd0,
        KIND_BEGIN = 2'd1,
        KIND_BYTE  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROOT_LD,
        ST_WALK
    } walk_state_t;

    typedef struct packed {
        logic [NODE_BITS-1:0]   left;
        logic [NODE_BITS-1:0]   right;
        logic                   leaf;
        logic [SYMBOL_BITS-1:0] sym;
    } node_t;

    typedef struct packed {
        logic                 valid;
        logic [OUT_SYM_W-1:0] symbol;
        logic                 done;
        logic                 closes;
    } push_t;

    typedef struct packed {
        logic walking;
        logic count_zero;
    } walk_stat_t;

    function automatic logic [NODE_BITS-1:0] node_addr(input logic [IDX_BITS-1:0] v);
        return NODE_BITS'(32'(v) % NODE_COUNT);
    endfunction

    function automatic logic [SYMBOL_BITS-1:0] sym_store(input logic [IN_SYM_W-1:0] s);
        return SYMBOL_BITS'(32'(s));
    endfunction

    function automatic logic [OUT_SYM_W-1:0] sym_out(input logic [SYMBOL_BITS-1:0] s);
        return OUT_SYM_W'(32'(s));
    endfunction

endpackage
`default_nettype wire

@@ src/huffman_tree_walk_decoder.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// huffman_tree_walk_decoder
// Huffman decoder: walks a node memory code tree, one bit a cycle unless stalled.
// ----------------------------------------------------------------------------
// Channel   Dir  Beat content
// s_*       in   tuser: kind; tdata: node_index, left_child, right_child,
//                is_leaf, leaf_symbol, code_byte
// m_*       out  tdata: symbol; tlast: last; tuser: stream_done
// cfg_*     in   cfg_index 0 root_node, 1 symbol_total; one write per cycle
//
// Node write and ignored beats need no read; a begin reads the root node.
// A code byte makes one node memory read per bit on the single read port,
// then takes in the last read; it ends early when the count runs out inside
// the byte. The first byte after root_node changes without a begin reads
// the root node first. A waiting byte with a zero count is dropped.
// Reset clears control state only; node memory is undefined until written.
// A stalled master side holds the walk on a leaf while two results wait.
// ----------------------------------------------------------------------------
module huffman_tree_walk_decoder (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [htwd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [htwd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [8:0] node_index, [17:9] left_child, [26:18] right_child, [27] is_leaf,
    // [35:28] leaf_symbol, [43:36] code_byte, [47:44] zero
    input  logic [htwd_pkg::IN_DATA_W-1:0]     s_tdata,
    // [1:0] kind
    input  logic [htwd_pkg::KIND_W-1:0]        s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [7:0] symbol
    output logic [htwd_pkg::OUT_SYM_W-1:0]     m_tdata,
    output logic                               m_tlast,
    // [0] stream_done
    output logic [0:0]                         m_tuser
);
    import htwd_pkg::*;

    logic                 mem_we;
    logic [NODE_BITS-1:0] mem_waddr;
    node_t                mem_wdata;
    logic                 mem_re;
    logic [NODE_BITS-1:0] mem_raddr;
    node_t                mem_rdata;
    push_t                push;
    logic                 push_ok;
    logic                 mark_last;
    walk_stat_t           stat;

    htwd_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    htwd_walk u_walk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .kind        (kind_t'(s_tuser)),
        .node_index  (s_tdata[8:0]),
        .left_child  (s_tdata[17:9]),
        .right_child (s_tdata[26:18]),
        .is_leaf     (s_tdata[27]),
        .leaf_symbol (s_tdata[35:28]),
        .code_byte   (s_tdata[43:36]),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata),
        .push        (push),
        .push_ok     (push_ok),
        .mark_last   (mark_last),
        .stat        (stat)
    );

    htwd_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_ok   (push_ok),
        .mark_last (mark_last),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("stream_done beat without tlast");

    a_walk_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        stat.walking |-> !stat.count_zero)
        else $error("walk running with zero symbols left");

    a_push_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> stat.walking)
        else $error("symbol pushed outside a walk");

    a_done_closes: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid && push.done |-> push.closes)
        else $error("final symbol not marked as closing the byte");

endmodule
`default_nettype wire

@@ src/htwd_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// htwd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module htwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

@@ src/htwd_walk.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// htwd_walk
// Input sequencer and tree walker: loads nodes, starts streams and steps the
// cursor through node memory one code bit per cycle while output is not stalled.
// ----------------------------------------------------------------------------
module htwd_walk (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [htwd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [htwd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  htwd_pkg::kind_t                     kind,
    input  logic [htwd_pkg::IDX_BITS-1:0]       node_index,
    input  logic [htwd_pkg::IDX_BITS-1:0]       left_child,
    input  logic [htwd_pkg::IDX_BITS-1:0]       right_child,
    input  logic                                is_leaf,
    input  logic [htwd_pkg::IN_SYM_W-1:0]       leaf_symbol,
    input  logic [htwd_pkg::BYTE_W-1:0]         code_byte,
    output logic                                mem_we,
    output logic [htwd_pkg::NODE_BITS-1:0]      mem_waddr,
    output htwd_pkg::node_t                     mem_wdata,
    output logic                                mem_re,
    output logic [htwd_pkg::NODE_BITS-1:0]      mem_raddr,
    input  htwd_pkg::node_t                     mem_rdata,
    output htwd_pkg::push_t                     push,
    input  logic                                push_ok,
    output logic                                mark_last,
    output htwd_pkg::walk_stat_t                stat
);
    import htwd_pkg::*;

    walk_state_t            state_reg,        state_next;
    logic [IDX_BITS-1:0]    root_reg,         root_next;
    logic [COUNT_W-1:0]     total_reg,        total_next;
    logic [COUNT_W-1:0]     symbols_left_reg, symbols_left_next;
    logic [NODE_BITS-1:0]   cursor_reg,       cursor_next;
    logic                   root_ok_reg,      root_ok_next;
    logic                   rd_pend_reg,      rd_pend_next;
    logic                   begin_reg,        begin_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg,      bit_cnt_next;
    logic [BYTE_W-1:0]      byte_reg,         byte_next;
    node_t                  cur_rec_reg,      cur_rec_next;
    node_t                  root_rec_reg,     root_rec_next;

    logic [NODE_BITS-1:0]   root_addr;
    node_t                  cur_eff;
    node_t                  wr_node;
    logic                   leaf_hit;
    logic                   done_hit;
    logic                   stall;
    logic                   more;
    logic [NODE_BITS-1:0]   step_addr;

    always_comb
    begin
        root_addr = node_addr(root_reg);
        if (rd_pend_reg)
        begin
            cur_eff = mem_rdata.leaf ? root_rec_reg : mem_rdata;
        end
        else
        begin
            cur_eff = cur_rec_reg;
        end
        wr_node.left  = node_addr(left_child);
        wr_node.right = node_addr(right_child);
        wr_node.leaf  = is_leaf;
        wr_node.sym   = sym_store(leaf_symbol);
        leaf_hit  = (state_reg == ST_WALK) && rd_pend_reg && mem_rdata.leaf;
        done_hit  = leaf_hit && (symbols_left_reg == COUNT_W'(1));
        stall     = leaf_hit && !push_ok;
        more      = bit_cnt_reg < BIT_CNT_W'(BITS_PER_BYTE);
        step_addr = byte_reg[BYTE_TOP_BIT] ? cur_eff.right : cur_eff.left;
    end

    always_comb
    begin
        state_next        = state_reg;
        root_next         = root_reg;
        total_next        = total_reg;
        symbols_left_next = symbols_left_reg;
        cursor_next       = cursor_reg;
        root_ok_next      = root_ok_reg;
        rd_pend_next      = rd_pend_reg;
        begin_next        = begin_reg;
        bit_cnt_next      = bit_cnt_reg;
        byte_next         = byte_reg;
        cur_rec_next      = cur_rec_reg;
        root_rec_next     = root_rec_reg;
        in_ready          = 1'b0;
        mem_we            = 1'b0;
        mem_waddr         = node_addr(node_index);
        mem_wdata         = wr_node;
        mem_re            = 1'b0;
        mem_raddr         = step_addr;
        push              = '0;
        mark_last         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (kind)
                        KIND_WRITE:
                        begin
                            mem_we = 1'b1;
                            if (mem_waddr == root_addr)
                            begin
                                root_rec_next = wr_node;
                            end
                            if (mem_waddr == cursor_reg)
                            begin
                                cur_rec_next = wr_node;
                            end
                        end
                        KIND_BEGIN:
                        begin
                            symbols_left_next = total_reg;
                            cursor_next       = root_addr;
                            mem_re            = 1'b1;
                            mem_raddr         = root_addr;
                            begin_next        = 1'b1;
                            state_next        = ST_ROOT_LD;
                        end
                        KIND_BYTE:
                        begin
                            if (symbols_left_reg != '0)
                            begin
                                if (root_ok_reg)
                                begin
                                    mem_re       = 1'b1;
                                    mem_raddr    = code_byte[BYTE_TOP_BIT] ?
                                                   cur_rec_reg.right : cur_rec_reg.left;
                                    cursor_next  = mem_raddr;
                                    byte_next    = {code_byte[BYTE_TOP_BIT-1:0], 1'b0};
                                    bit_cnt_next = BIT_CNT_W'(1);
                                    rd_pend_next = 1'b1;
                                    state_next   = ST_WALK;
                                end
                                else
                                begin
                                    mem_re       = 1'b1;
                                    mem_raddr    = root_addr;
                                    byte_next    = code_byte;
                                    bit_cnt_next = '0;
                                    rd_pend_next = 1'b0;
                                    begin_next   = 1'b0;
                                    state_next   = ST_ROOT_LD;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_ROOT_LD:
            begin
                root_rec_next = mem_rdata;
                root_ok_next  = 1'b1;
                if (begin_reg)
                begin
                    cur_rec_next = mem_rdata;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (!stall)
                begin
                    if (leaf_hit)
                    begin
                        push.valid        = 1'b1;
                        push.symbol       = sym_out(mem_rdata.sym);
                        push.done         = done_hit;
                        push.closes       = done_hit || !more;
                        symbols_left_next = symbols_left_reg - COUNT_W'(1);
                    end
                    if (more && !done_hit)
                    begin
                        mem_re       = 1'b1;
                        mem_raddr    = step_addr;
                        cursor_next  = step_addr;
                        byte_next    = {byte_reg[BYTE_TOP_BIT-1:0], 1'b0};
                        bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
                        rd_pend_next = 1'b1;
                    end
                    else
                    begin
                        cur_rec_next = cur_eff;
                        cursor_next  = leaf_hit ? root_addr : cursor_reg;
                        rd_pend_next = 1'b0;
                        mark_last    = !leaf_hit;
                        state_next   = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROOT_NODE:
                begin
                    root_next    = cfg_data[IDX_BITS-1:0];
                    root_ok_next = 1'b0;
                end
                CFG_SYMBOL_TOTAL:
                begin
                    total_next = cfg_data[COUNT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            root_reg         <= '0;
            total_reg        <= '0;
            symbols_left_reg <= '0;
            cursor_reg       <= '0;
            root_ok_reg      <= 1'b0;
            rd_pend_reg      <= 1'b0;
            begin_reg        <= 1'b0;
            bit_cnt_reg      <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            root_reg         <= root_next;
            total_reg        <= total_next;
            symbols_left_reg <= symbols_left_next;
            cursor_reg       <= cursor_next;
            root_ok_reg      <= root_ok_next;
            rd_pend_reg      <= rd_pend_next;
            begin_reg        <= begin_next;
            bit_cnt_reg      <= bit_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        cur_rec_reg  <= cur_rec_next;
        root_rec_reg <= root_rec_next;
    end

    assign stat.walking    = (state_reg == ST_WALK);
    assign stat.count_zero = (symbols_left_reg == '0);

endmodule
`default_nettype wire

@@ src/htwd_out.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// htwd_out
// Result stage: holds one symbol back to know its last flag, then drives the
// master-side beat register.
// ----------------------------------------------------------------------------
module htwd_out (
    input  logic                             clk,
    input  logic                             rst_n,
    input  htwd_pkg::push_t                  push,
    output logic                             push_ok,
    input  logic                             mark_last,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [htwd_pkg::OUT_SYM_W-1:0]   m_tdata,
    output logic                             m_tlast,
    output logic [0:0]                       m_tuser
);
    import htwd_pkg::*;

    logic                 pend_valid_reg, pend_valid_next;
    logic [OUT_SYM_W-1:0] pend_sym_reg,   pend_sym_next;
    logic                 pend_done_reg,  pend_done_next;
    logic                 pend_last_reg,  pend_last_next;
    logic                 out_valid_reg,  out_valid_next;
    logic [OUT_SYM_W-1:0] out_sym_reg,    out_sym_next;
    logic                 out_last_reg,   out_last_next;
    logic                 out_done_reg,   out_done_next;

    logic out_free;
    logic move;

    always_comb
    begin
        out_free = !out_valid_reg || m_tready;
        move     = pend_valid_reg && out_free && (pend_last_reg || push.valid);
        push_ok  = !pend_valid_reg || out_free;

        out_valid_next  = out_valid_reg && !m_tready;
        out_sym_next    = out_sym_reg;
        out_last_next   = out_last_reg;
        out_done_next   = out_done_reg;
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        pend_done_next  = pend_done_reg;
        pend_last_next  = pend_last_reg;

        if (move)
        begin
            out_valid_next = 1'b1;
            out_sym_next   = pend_sym_reg;
            out_last_next  = pend_last_reg;
            out_done_next  = pend_done_reg;
        end

        if (push.valid)
        begin
            pend_valid_next = 1'b1;
            pend_sym_next   = push.symbol;
            pend_done_next  = push.done;
            pend_last_next  = push.closes;
        end
        else if (move)
        begin
            pend_valid_next = 1'b0;
        end
        else if (mark_last && pend_valid_reg)
        begin
            pend_last_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_sym_reg  <= pend_sym_next;
        pend_done_reg <= pend_done_next;
        pend_last_reg <= pend_last_next;
        out_sym_reg   <= out_sym_next;
        out_last_reg  <= out_last_next;
        out_done_reg  <= out_done_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_sym_reg;
    assign m_tlast    = out_last_reg;
    assign m_tuser[0] = out_done_reg;

endmodule
`default_nettype wire

@@ verif/huffman_tree_walk_decoder_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_tree_walk_decoder_test
// Loads code trees into node memory through node-write beats and points the
// root and symbol count registers at them. It then streams begin and code
// byte beats, with ignored kinds, stray node writes and padding mixed in. A
// tree walk kept alongside the block predicts every symbol, its last flag and
// its stream-done flag, and each output beat is checked against the oldest
// prediction. Both sides stall at random, and one long output stall fills the
// block. Walks only ever touch nodes that have already been written.
// ----------------------------------------------------------------------------
module huffman_tree_walk_decoder_test;

    import htwd_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int IDLE_PCT      = 19;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 16;
    localparam int QUIET_LIMIT   = 3000;
    localparam int ITEM_TARGET   = 320;

    typedef struct {
        logic [KIND_W-1:0]   kind;
        logic [IDX_BITS-1:0] node_index;
        logic [IDX_BITS-1:0] left_child;
        logic [IDX_BITS-1:0] right_child;
        logic                is_leaf;
        logic [IN_SYM_W-1:0] leaf_symbol;
        logic [BYTE_W-1:0]   code_byte;
    } code_beat_t;

    typedef struct {
        logic [OUT_SYM_W-1:0] symbol;
        logic                 last;
        logic                 done;
    } symbol_beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic [KIND_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_SYM_W-1:0] m_tdata;
    logic m_tlast;
    logic [0:0] m_tuser;

    // tree walk state
    bit [NODE_BITS-1:0]   tree_left [NODE_COUNT];
    bit [NODE_BITS-1:0]   tree_right [NODE_COUNT];
    bit                   tree_leaf [NODE_COUNT];
    bit [SYMBOL_BITS-1:0] tree_sym [NODE_COUNT];
    bit [NODE_BITS-1:0]   walk_node;
    bit [COUNT_W-1:0]     walk_left;
    bit [NODE_BITS-1:0]   cfg_root;
    bit [COUNT_W-1:0]     cfg_total;

    symbol_beat_t symbol_q[$];
    code_beat_t   stream_q[$];
    code_beat_t   drive_item;
    bit           beat_taken;
    bit           node_known [NODE_COUNT];
    int           known_nodes[$];
    int           items_queued;
    int           items_accepted;
    int           quiet_cycles;
    int           mismatches;
    int           rx_hold;
    bit           steady;

    huffman_tree_walk_decoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 40)
            $display("ERROR %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $time);
    endtask

    task automatic walk_tree_beat(input code_beat_t it);
        symbol_beat_t r;
        bit [NODE_BITS-1:0] nxt;
        int first;
        if (it.kind == KIND_WRITE)
        begin
            tree_left[it.node_index]  = it.left_child;
            tree_right[it.node_index] = it.right_child;
            tree_leaf[it.node_index]  = it.is_leaf;
            tree_sym[it.node_index]   = it.leaf_symbol;
        end
        else if (it.kind == KIND_BEGIN)
        begin
            walk_node = cfg_root;
            walk_left = cfg_total;
        end
        else if (it.kind == KIND_BYTE && walk_left != 0)
        begin
            first = symbol_q.size();
            for (int b = BYTE_TOP_BIT; b >= 0; b--)
            begin
                nxt = it.code_byte[b] ? tree_right[walk_node] : tree_left[walk_node];
                walk_node = nxt;
                if (tree_leaf[nxt])
                begin
                    walk_left--;
                    r.symbol = tree_sym[nxt];
                    r.last   = 1'b0;
                    r.done   = (walk_left == 0);
                    symbol_q.push_back(r);
                    walk_node = cfg_root;
                    if (walk_left == 0)
                        break;
                end
            end
            if (symbol_q.size() > first)
            begin
                r = symbol_q.pop_back();
                r.last = 1'b1;
                symbol_q.push_back(r);
            end
        end
    endtask

    function automatic code_beat_t random_beat(input logic [KIND_W-1:0] kind);
        code_beat_t nb;
        nb.kind        = kind;
        nb.node_index  = IDX_BITS'($urandom);
        nb.left_child  = IDX_BITS'($urandom);
        nb.right_child = IDX_BITS'($urandom);
        nb.is_leaf     = 1'($urandom);
        nb.leaf_symbol = IN_SYM_W'($urandom);
        nb.code_byte   = BYTE_W'($urandom);
        return nb;
    endfunction

    function automatic void learn_node(input int idx);
        if (!node_known[idx])
        begin
            node_known[idx] = 1'b1;
            known_nodes.push_back(idx);
        end
    endfunction

    function automatic int pick_known();
        return known_nodes[$urandom_range(known_nodes.size() - 1)];
    endfunction

    task automatic push_beat(input code_beat_t nb);
        stream_q.push_back(nb);
        items_queued++;
    endtask

    task automatic queue_kind(input logic [KIND_W-1:0] kind);
        push_beat(random_beat(kind));
    endtask

    task automatic queue_byte(input logic [BYTE_W-1:0] value);
        code_beat_t nb;
        nb = random_beat(KIND_BYTE);
        nb.code_byte = value;
        push_beat(nb);
    endtask

    task automatic queue_node(input int idx, input int l, input int r, input bit leaf,
                              input int sym);
        code_beat_t nb;
        nb = random_beat(KIND_WRITE);
        nb.node_index  = IDX_BITS'(idx);
        nb.left_child  = IDX_BITS'(l);
        nb.right_child = IDX_BITS'(r);
        nb.is_leaf     = leaf;
        nb.leaf_symbol = IN_SYM_W'(sym);
        learn_node(idx);
        push_beat(nb);
    endtask

    // Build a random full tree, writing children before their parents.
    task automatic queue_tree(input int root, input int nleaves, input bit chain);
        int addr [32];
        int lc [32];
        int rc [32];
        int open_q[$];
        bit used [NODE_COUNT];
        int cnt;
        int leaves;
        int p;
        int k;
        int a;
        addr[0] = root;
        lc[0] = -1;
        rc[0] = -1;
        used[root] = 1'b1;
        cnt = 1;
        leaves = 1;
        open_q.push_back(0);
        while (leaves < nleaves)
        begin
            k = chain ? open_q.size() - 1 : $urandom_range(open_q.size() - 1);
            p = open_q[k];
            open_q.delete(k);
            for (int c = 0; c < 2; c++)
            begin
                do a = $urandom_range(NODE_COUNT - 1); while (used[a]);
                used[a] = 1'b1;
                addr[cnt] = a;
                lc[cnt] = -1;
                rc[cnt] = -1;
                open_q.push_back(cnt);
                cnt++;
            end
            lc[p] = cnt - 2;
            rc[p] = cnt - 1;
            leaves++;
        end
        for (int i = cnt - 1; i >= 0; i--)
        begin
            if (lc[i] < 0)
            begin
                learn_node(addr[i]);
                queue_node(addr[i], pick_known(), pick_known(), 1'b1, $urandom_range(255));
            end
            else
            begin
                queue_node(addr[i], addr[lc[i]], addr[rc[i]],
                           i == 0 && $urandom_range(3) == 0, $urandom_range(255));
            end
        end
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == CFG_ROOT_NODE)
            cfg_root = value[NODE_BITS-1:0];
        else
            cfg_total = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Drain all beats and symbols, then let the walk come to rest.
    task automatic settle(input int cycles);
        wait (items_accepted == items_queued);
        wait (symbol_q.size() == 0);
        repeat (cycles) @(posedge clk);
    endtask

    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || beat_taken))
        begin
            beat_taken = 1'b0;
            if (stream_q.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT))
            begin
                drive_item = stream_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= drive_item.kind;
                s_tdata  <= {4'b0, drive_item.code_byte, drive_item.leaf_symbol,
                             drive_item.is_leaf, drive_item.right_child,
                             drive_item.left_child, drive_item.node_index};
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            rx_hold--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        symbol_beat_t want;
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (s_tvalid && s_tready)
            begin
                walk_tree_beat(drive_item);
                beat_taken = 1'b1;
                items_accepted++;
            end
            if (m_tvalid && m_tready)
            begin
                if (symbol_q.size() == 0)
                begin
                    report_mismatch("symbol beat with none pending", m_tdata, 0);
                end
                else
                begin
                    want = symbol_q.pop_front();
                    if (m_tdata !== want.symbol)
                        report_mismatch("symbol", m_tdata, want.symbol);
                    if (m_tlast !== want.last)
                        report_mismatch("last", m_tlast, want.last);
                    if (m_tuser[0] !== want.done)
                        report_mismatch("stream_done", m_tuser[0], want.done);
                end
            end
        end
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("ERROR watchdog: no beat for %0d cycles", QUIET_LIMIT);
        $display("huffman_tree_walk_decoder: mismatch");
        $finish;
    end

    initial
    begin
        int seg;
        int pick;
        int root;
        int nleaves;
        int nbytes;
        logic [CFG_DATA_W-1:0] total;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // count still zero from reset, then a two-leaf tree that runs out mid-byte
        write_cfg(CFG_ROOT_NODE, 0);
        write_cfg(CFG_SYMBOL_TOTAL, 3);
        queue_byte(8'h81);
        queue_kind(KIND_UNUSED);
        queue_node(1, 1, 1, 1'b1, 8'hFF);
        queue_node(3, 3, 3, 1'b1, 8'h00);
        queue_node(2, 2, 2, 1'b0, 8'h00);
        queue_node(0, 1, 3, 1'b0, 8'hA5);
        queue_kind(KIND_BEGIN);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        settle(SETTLE_CYCLES);

        // endless count: eight symbols a byte, then rewire root into a dead loop
        write_cfg(CFG_SYMBOL_TOTAL, '1);
        queue_kind(KIND_BEGIN);
        queue_byte(8'hA5);
        queue_byte(8'hFF);
        queue_node(0, 1, 2, 1'b0, 8'h3C);
        queue_byte(8'h7F);
        queue_byte(8'h00);
        queue_kind(KIND_BEGIN);
        queue_byte(8'h80);
        settle(SETTLE_CYCLES);

        // root at the top index, marked as a leaf, with a zero count
        write_cfg(CFG_ROOT_NODE, NODE_COUNT - 1);
        write_cfg(CFG_SYMBOL_TOTAL, 0);
        queue_node(NODE_COUNT - 1, 1, 3, 1'b1, 8'h5A);
        queue_kind(KIND_BEGIN);
        queue_byte(8'h3C);
        settle(SETTLE_CYCLES);

        write_cfg(CFG_SYMBOL_TOTAL, 2);
        queue_kind(KIND_BEGIN);
        queue_byte(8'h40);

        seg = 0;
        while (items_queued < ITEM_TARGET)
        begin
            settle(SETTLE_CYCLES);
            steady = (seg == 2);
            pick = $urandom_range(3);
            root = (pick == 0) ? 0 : (pick == 1) ? NODE_COUNT - 1
                                                 : $urandom_range(NODE_COUNT - 1);
            case ($urandom_range(9))
                0: total = '0;
                1: total = '1;
                2: total = 1;
                default: total = $urandom_range(40, 2);
            endcase
            nleaves = $urandom_range(12, 2);
            nbytes = (seg == 2) ? 24 : $urandom_range(20, 4);
            if (seg == 4)
            begin
                total = '1;
                nleaves = 2;
                nbytes = 30;
            end
            write_cfg(CFG_ROOT_NODE, root);
            write_cfg(CFG_SYMBOL_TOTAL, total);
            queue_tree(root, nleaves, $urandom_range(3) == 0);
            queue_kind(KIND_BEGIN);
            if (seg == 4)
                rx_hold = HOLD_CYCLES;
            for (int i = 0; i < nbytes; i++)
            begin
                if (i == nbytes / 2 && (seg == 1 || seg == 5))
                    settle(0);
                pick = $urandom_range(99);
                if (pick < 80)
                    queue_byte(BYTE_W'($urandom_range(255)));
                else if (pick < 86)
                    queue_byte(pick[0] ? 8'hFF : 8'h00);
                else if (pick < 90)
                    queue_kind(KIND_UNUSED);
                else if (pick < 95)
                    queue_node($urandom_range(NODE_COUNT - 1), pick_known(), pick_known(),
                               1'($urandom_range(1)), $urandom_range(255));
                else
                    queue_kind(KIND_BEGIN);
            end
            seg++;
        end
        steady = 1'b0;

        wait (items_accepted == items_queued);
        wait (symbol_q.size() == 0);
        repeat (SETTLE_CYCLES + 4) @(posedge clk);
        if (mismatches == 0)
            $display("huffman_tree_walk_decoder: match");
        else
            $display("huffman_tree_walk_decoder: mismatch");
        $finish;
    end

endmodule
